// ===== design/mcpet_pkg.sv =====
// Shared types and constants for the multi-channel periodic event timer.
// No dependencies; imported by the top level.
`default_nettype none
package mcpet_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 16;
  localparam int unsigned ID_W             = 5;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned POW_W            = 20;
  localparam int unsigned TB_W             = 3;
  localparam logic [TB_W-1:0] TB_MAX       = 3'd6;
  localparam logic [TB_W-1:0] TB_RESET     = 3'd3;

  typedef enum logic [2:0] {
    FN_CONNECT = 3'd0,
    FN_ENABLE  = 3'd1,
    FN_DISABLE = 3'd2,
    FN_START   = 3'd3,
    FN_STOP    = 3'd4,
    FN_TICK    = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONN_DIV,
    ST_CONN_MUL,
    ST_CONN_FIN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_DIV,
    ST_SCAN_NEXT,
    ST_SCAN_FIN
  } state_t;

  // decade ratio 10**n for n = 0..6
  function automatic logic [POW_W-1:0] pow10_f(input logic [TB_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/multi_channel_periodic_event_timer_top.sv =====
// Top level of the multi-channel periodic event timer: command port, config
// port, channel store and shared 32-bit restoring divider. Uses mcpet_pkg.
`default_nettype none
// Usage
//   Command channel: present in_func/in_count/in_timebase/in_channel_id with
//   start high; the word is taken on a rising edge where busy is low.
//   Result channel: each result word sits on out_* for one cycle, marked by
//   out_strobe; out_last flags the final word of a command. There is no
//   back-pressure: the receiver must take every word as it comes.
//   Config channel: cfg_ready is always high; a cfg_data value of 7 is dropped.
//   Write it only while the block is idle.
// Command flow
//   Enable, disable, start, stop, unknown codes, refused connects and ticks
//   while stopped answer in the cycle after acceptance, busy stays low.
//   A connect at a finer timebase runs the divider: its 32 steps, then a
//   closing state, and the word comes out as busy drops.
//   One at the same or a coarser timebase multiplies in one step instead.
//   A running tick walks the used channels one at a time; an enabled channel
//   passes read, check, the 32 divider steps and advance, a disabled one read,
//   check and advance, then one closing state ends the scan; busy throughout.
// Reset
//   rst_n low clears the counter, enables, fill count, run flag and sets the
//   base timebase to 3; the compare store is not cleared (never read unwritten).
module multi_channel_periodic_event_timer_top
  import mcpet_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_func,
  input  wire logic [DATA_W-1:0] in_count,
  input  wire logic [TB_W-1:0]   in_timebase,
  input  wire logic [ID_W-1:0]   in_channel_id,
  output logic                   out_strobe,
  output logic                   out_status,
  output logic [ID_W-1:0]        out_assigned_id,
  output logic                   out_fired,
  output logic [ID_W-1:0]        out_fired_id,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TB_W-1:0]   cfg_data
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned PROD_W = DATA_W + POW_W;

  state_t state_r, state_nxt;

  logic [TB_W-1:0]   base_r, base_nxt;
  logic [DATA_W-1:0] tick_r, tick_nxt;
  logic              run_r, run_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [MAX_CHANNELS-1:0] en_r, en_nxt;

  // compare store: one write port, one registered read port
  logic [DATA_W-1:0] cmp_mem [MAX_CHANNELS];
  logic [DATA_W-1:0] rd_r;
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;

  // shared divider
  logic [DATA_W-1:0] div_rem_r, div_rem_nxt;
  logic [DATA_W-1:0] div_quo_r, div_quo_nxt;
  logic [DATA_W-1:0] div_dsr_r, div_dsr_nxt;
  logic [4:0]        div_cnt_r, div_cnt_nxt;
  logic [DATA_W:0]   div_sh;
  logic              div_ge;
  logic              div_done;

  logic [DATA_W-1:0] op_count_r, op_count_nxt;
  logic [POW_W-1:0]  op_pow_r, op_pow_nxt;
  logic              conn_div_r, conn_div_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // scan bookkeeping
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  logic              pend_r, pend_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  logic              out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_aid_r, out_aid_nxt;
  logic              out_fired_r, out_fired_nxt;
  logic [ID_W-1:0]   out_fid_r, out_fid_nxt;
  logic              out_last_r, out_last_nxt;

  // decode helpers
  logic              accept;
  func_t             fn;
  logic              full;
  logic              conn_ok;
  logic              tb_fine;
  logic [TB_W-1:0]   pow_idx;
  logic [31:0]       cid_m1;
  logic              cid_ok;
  logic [IDX_W-1:0]  cid_idx;
  logic              scan_last;
  logic [31:0]       cur_id;
  logic [31:0]       new_id;
  logic              chan_live;
  logic              conn_fail;
  logic [DATA_W-1:0] conn_cmp;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign fn        = func_t'(in_func);

  assign full    = (32'(used_r) >= MAX_CHANNELS);
  assign tb_fine = (in_timebase < base_r);
  assign pow_idx = tb_fine ? (base_r - in_timebase) : (in_timebase - base_r);
  assign conn_ok = !run_r && (in_timebase <= TB_MAX) && (in_count != '0) && !full;

  assign cid_m1  = 32'(in_channel_id) - 32'd1;
  assign cid_ok  = (in_channel_id != '0) && (32'(in_channel_id) <= 32'(used_r));
  assign cid_idx = cid_m1[IDX_W-1:0];

  assign scan_last = (32'(idx_r) + 32'd1 >= 32'(used_r));
  assign cur_id    = 32'(idx_r) + 32'd1;
  assign new_id    = 32'(used_r) + 32'd1;
  assign chan_live = en_r[idx_r] && (rd_r != '0);

  assign conn_fail = conn_div_r ? (div_rem_r != '0) : (prod_r[PROD_W-1:DATA_W] != '0);
  assign conn_cmp  = conn_div_r ? div_quo_r : prod_r[DATA_W-1:0];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_sh   = {div_rem_r, div_quo_r[DATA_W-1]};
  assign div_ge   = (div_sh >= {1'b0, div_dsr_r});
  assign div_done = (div_cnt_r == 5'd31);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (fn)
            FN_CONNECT: begin
              if (conn_ok) state_nxt = tb_fine ? ST_CONN_DIV : ST_CONN_MUL;
            end
            FN_TICK: begin
              if (run_r) state_nxt = (used_r != '0) ? ST_SCAN_RD : ST_SCAN_FIN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONN_DIV:  if (div_done) state_nxt = ST_CONN_FIN;
      ST_CONN_MUL:  state_nxt = ST_CONN_FIN;
      ST_CONN_FIN:  state_nxt = ST_IDLE;
      ST_SCAN_RD:   state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK:  state_nxt = chan_live ? ST_SCAN_DIV : ST_SCAN_NEXT;
      ST_SCAN_DIV:  if (div_done) state_nxt = ST_SCAN_NEXT;
      ST_SCAN_NEXT: state_nxt = scan_last ? ST_SCAN_FIN : ST_SCAN_RD;
      ST_SCAN_FIN:  state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    base_nxt     = base_r;
    tick_nxt     = tick_r;
    run_nxt      = run_r;
    used_nxt     = used_r;
    en_nxt       = en_r;
    mem_we       = 1'b0;
    mem_wdata    = conn_cmp;
    div_rem_nxt  = div_rem_r;
    div_quo_nxt  = div_quo_r;
    div_dsr_nxt  = div_dsr_r;
    div_cnt_nxt  = div_cnt_r;
    op_count_nxt = op_count_r;
    op_pow_nxt   = op_pow_r;
    conn_div_nxt = conn_div_r;
    prod_nxt     = prod_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    pend_nxt     = pend_r;
    pend_id_nxt  = pend_id_r;

    out_strobe_nxt = 1'b0;
    out_status_nxt = 1'b0;
    out_aid_nxt    = '0;
    out_fired_nxt  = 1'b0;
    out_fid_nxt    = '0;
    out_last_nxt   = 1'b1;

    if (cfg_valid && (cfg_data <= TB_MAX)) base_nxt = cfg_data;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (fn)
            FN_CONNECT: begin
              if (conn_ok) begin
                op_count_nxt = in_count;
                op_pow_nxt   = pow10_f(pow_idx);
                conn_div_nxt = tb_fine;
                div_rem_nxt  = '0;
                div_quo_nxt  = in_count;
                div_dsr_nxt  = DATA_W'(pow10_f(pow_idx));
                div_cnt_nxt  = '0;
              end else begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            FN_ENABLE, FN_DISABLE: begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = !cid_ok;
              if (cid_ok) en_nxt[cid_idx] = (fn == FN_ENABLE);
            end
            FN_START: begin
              run_nxt        = 1'b1;
              out_strobe_nxt = 1'b1;
            end
            FN_STOP: begin
              run_nxt        = 1'b0;
              out_strobe_nxt = 1'b1;
            end
            FN_TICK: begin
              if (run_r) begin
                tick_nxt = tick_r + 32'd1;
                idx_nxt  = '0;
                pend_nxt = 1'b0;
              end else begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_CONN_DIV, ST_SCAN_DIV: begin
        div_rem_nxt = div_ge ? DATA_W'(div_sh - {1'b0, div_dsr_r}) : div_sh[DATA_W-1:0];
        div_quo_nxt = {div_quo_r[DATA_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (state_r == ST_SCAN_DIV && div_done) begin
          hit_nxt = !div_ge && (div_sh[DATA_W-1:0] == '0) ||
                    div_ge && (div_sh == {1'b0, div_dsr_r});
        end
      end
      ST_CONN_MUL: begin
        prod_nxt = PROD_W'(op_count_r) * PROD_W'(op_pow_r);
      end
      ST_CONN_FIN: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = conn_fail;
        if (!conn_fail) begin
          mem_we                     = 1'b1;
          en_nxt[used_r[IDX_W-1:0]]  = 1'b0;
          used_nxt                   = used_r + CNT_W'(1);
          out_aid_nxt                = new_id[ID_W-1:0];
        end
      end
      ST_SCAN_RD: begin
        hit_nxt = 1'b0;
      end
      ST_SCAN_CHK: begin
        // load the divider with counter and compare value
        div_rem_nxt = '0;
        div_quo_nxt = tick_r;
        div_dsr_nxt = rd_r;
        div_cnt_nxt = '0;
      end
      ST_SCAN_NEXT: begin
        // hold one hit back so the final one can carry the last flag
        if (hit_r) begin
          if (pend_r) begin
            out_strobe_nxt = 1'b1;
            out_fired_nxt  = 1'b1;
            out_fid_nxt    = pend_id_r;
            out_last_nxt   = 1'b0;
          end
          pend_nxt    = 1'b1;
          pend_id_nxt = cur_id[ID_W-1:0];
        end
        if (!scan_last) idx_nxt = idx_r + IDX_W'(1);
      end
      ST_SCAN_FIN: begin
        out_strobe_nxt = 1'b1;
        out_fired_nxt  = pend_r;
        out_fid_nxt    = pend_r ? pend_id_r : '0;
        pend_nxt       = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= TB_RESET;
      tick_r       <= '0;
      run_r        <= 1'b0;
      used_r       <= '0;
      en_r         <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      tick_r       <= tick_nxt;
      run_r        <= run_nxt;
      used_r       <= used_nxt;
      en_r         <= en_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r    <= div_rem_nxt;
    div_quo_r    <= div_quo_nxt;
    div_dsr_r    <= div_dsr_nxt;
    div_cnt_r    <= div_cnt_nxt;
    op_count_r   <= op_count_nxt;
    op_pow_r     <= op_pow_nxt;
    conn_div_r   <= conn_div_nxt;
    prod_r       <= prod_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_aid_r    <= out_aid_nxt;
    out_fired_r  <= out_fired_nxt;
    out_fid_r    <= out_fid_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) cmp_mem[used_r[IDX_W-1:0]] <= mem_wdata;
    rd_r <= cmp_mem[idx_r];
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_aid_r;
  assign out_fired       = out_fired_r;
  assign out_fired_id    = out_fid_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ===== sim/mcpet_checker.sv =====
`timescale 1ns / 100ps
// Checker for the multi-channel periodic event timer: watches the command, config
// and result channels, predicts each result word and compares. Uses mcpet_pkg.
module mcpet_checker
  import mcpet_pkg::*;
#(
  parameter int unsigned N_CHAN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [2:0]        in_func,
  input  wire logic [DATA_W-1:0] in_count,
  input  wire logic [TB_W-1:0]   in_timebase,
  input  wire logic [ID_W-1:0]   in_channel_id,
  input  wire logic              out_strobe,
  input  wire logic              out_status,
  input  wire logic [ID_W-1:0]   out_assigned_id,
  input  wire logic              out_fired,
  input  wire logic [ID_W-1:0]   out_fired_id,
  input  wire logic              out_last,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [TB_W-1:0]   cfg_data,
  output int                     mismatches,
  output int                     pending
);

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] assigned_id;
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            last;
  } timer_word_t;

  timer_word_t       word_q[$];
  logic [TB_W-1:0]   base_tb;
  logic [31:0]       ticks;
  logic [31:0]       period[N_CHAN];
  logic              armed[N_CHAN];
  int unsigned       n_used;
  logic              running;

  function automatic logic [31:0] decade(input int unsigned n);
    logic [31:0] p;
    p = 1;
    for (int unsigned k = 0; k < n; k++) p = p * 10;
    return p;
  endfunction

  function automatic timer_word_t mk_word(input logic st, input logic [ID_W-1:0] aid,
                                          input logic fr, input logic [ID_W-1:0] fid,
                                          input logic lst);
    timer_word_t w;
    w.status = st; w.assigned_id = aid; w.fired = fr; w.fired_id = fid; w.last = lst;
    return w;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // derive the compare value; store it if the connect is accepted and push the acknowledgement word
  task automatic predict_connect(input logic [31:0] cnt, input logic [TB_W-1:0] tb);
    logic        refused;
    logic [63:0] prod;
    logic [31:0] ratio;
    logic [31:0] cmp;
    refused = running || tb > TB_MAX || cnt == 0 || n_used >= N_CHAN;
    cmp = 0;
    if (!refused) begin
      if (tb < base_tb) begin
        ratio = decade(32'(base_tb - tb));
        if (cnt % ratio != 0) refused = 1;
        cmp = cnt / ratio;
      end else begin
        prod = 64'(cnt) * 64'(decade(32'(tb - base_tb)));
        if (prod[63:32] != 0) refused = 1;
        cmp = prod[31:0];
      end
    end
    if (refused) begin
      word_q.push_back(mk_word(1'b1, '0, 1'b0, '0, 1'b1));
    end else begin
      period[n_used] = cmp;
      armed[n_used]  = 1'b0;
      n_used++;
      word_q.push_back(mk_word(1'b0, ID_W'(n_used), 1'b0, '0, 1'b1));
    end
  endtask

  task automatic predict_tick();
    int n_fired;
    n_fired = 0;
    if (!running) begin
      word_q.push_back(mk_word(1'b1, '0, 1'b0, '0, 1'b1));
    end else begin
      ticks = ticks + 1;
      for (int unsigned i = 0; i < n_used; i++) begin
        if (armed[i] && period[i] != 0 && ticks % period[i] == 0) begin
          word_q.push_back(mk_word(1'b0, '0, 1'b1, ID_W'(i + 1), 1'b0));
          n_fired++;
        end
      end
      if (n_fired == 0) word_q.push_back(mk_word(1'b0, '0, 1'b0, '0, 1'b1));
      else word_q[$].last = 1'b1;
    end
  endtask

  task automatic predict_command();
    logic bad_id;
    bad_id = in_channel_id == 0 || in_channel_id > n_used;
    case (func_t'(in_func))
      FN_CONNECT: predict_connect(in_count, in_timebase);
      FN_ENABLE, FN_DISABLE: begin
        if (!bad_id) armed[in_channel_id - 1] = (in_func == FN_ENABLE);
        word_q.push_back(mk_word(bad_id, '0, 1'b0, '0, 1'b1));
      end
      FN_START, FN_STOP: begin
        running = (in_func == FN_START);
        word_q.push_back(mk_word(1'b0, '0, 1'b0, '0, 1'b1));
      end
      FN_TICK: predict_tick();
      default: word_q.push_back(mk_word(1'b1, '0, 1'b0, '0, 1'b1));
    endcase
  endtask

  initial mismatches = 0;
  assign pending = word_q.size();

  always @(posedge clk) begin
    timer_word_t want;
    if (!rst_n) begin
      word_q.delete();
      base_tb = TB_RESET;
      ticks   = 0;
      n_used  = 0;
      running = 0;
      for (int i = 0; i < N_CHAN; i++) armed[i] = 1'b0;
    end else begin
      // compare first: a result word never belongs to a command taken this edge
      if (out_strobe) begin
        if (word_q.size() == 0) begin
          report("unexpected result word, fired_id", 32'(out_fired_id), 32'd0);
        end else begin
          want = word_q.pop_front();
          if (out_status != want.status)
            report("status", 32'(out_status), 32'(want.status));
          if (out_assigned_id != want.assigned_id)
            report("assigned_id", 32'(out_assigned_id), 32'(want.assigned_id));
          if (out_fired != want.fired)
            report("fired", 32'(out_fired), 32'(want.fired));
          if (out_fired_id != want.fired_id)
            report("fired_id", 32'(out_fired_id), 32'(want.fired_id));
          if (out_last != want.last)
            report("last", 32'(out_last), 32'(want.last));
        end
      end
      if (cfg_valid && cfg_ready && cfg_data <= TB_MAX) base_tb = cfg_data;
      if (start && !busy) predict_command();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the multi-channel periodic event timer: clock, reset, command
// and config stimulus, verdict. Depends on mcpet_pkg, the timer top and mcpet_checker.
module tb;
  import mcpet_pkg::*;

  localparam int unsigned N_CHAN = 16;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_func;
  logic [DATA_W-1:0] in_count;
  logic [TB_W-1:0]   in_timebase;
  logic [ID_W-1:0]   in_channel_id;
  logic              out_strobe;
  logic              out_status;
  logic [ID_W-1:0]   out_assigned_id;
  logic              out_fired;
  logic [ID_W-1:0]   out_fired_id;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TB_W-1:0]   cfg_data;
  int                mismatches;
  int                pending;

  // percentage of slots in which the sender holds back a word
  int unsigned       gap_pct;
  // base timebase currently programmed, used to shape well-formed connects
  logic [TB_W-1:0]   cur_base;

  multi_channel_periodic_event_timer_top #(.MAX_CHANNELS(N_CHAN)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_count(in_count), .in_timebase(in_timebase),
    .in_channel_id(in_channel_id),
    .out_strobe(out_strobe), .out_status(out_status), .out_assigned_id(out_assigned_id),
    .out_fired(out_fired), .out_fired_id(out_fired_id), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mcpet_checker #(.N_CHAN(N_CHAN)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_count(in_count), .in_timebase(in_timebase),
    .in_channel_id(in_channel_id),
    .out_strobe(out_strobe), .out_status(out_status), .out_assigned_id(out_assigned_id),
    .out_fired(out_fired), .out_fired_id(out_fired_id), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop: the slowest legal run is far below this
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Present one command word and hold it until the edge that takes it.
  // Idle slots drop start first, so start is never lowered and raised in one step.
  task automatic send(input logic [2:0] fn, input logic [31:0] cnt,
                      input logic [TB_W-1:0] tb, input logic [ID_W-1:0] id);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= fn;
    in_count      <= cnt;
    in_timebase   <= tb;
    in_channel_id <= id;
    do @(posedge clk); while (busy);
  endtask

  // Quiesce, then write the base timebase. Every command answers with at least
  // one word, so once nothing is pending a short settle covers the closing cycle.
  task automatic write_base(input logic [TB_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (v <= TB_MAX) cur_base = v;
  endtask

  // Connect with a small compare value so that channels fire often;
  // sometimes at a finer timebase with an exactly divisible count.
  task automatic connect_small();
    int unsigned d;
    d = $urandom_range((cur_base < 3) ? cur_base : 3, 0);
    send(FN_CONNECT, $urandom_range(12, 1) * (10 ** d), cur_base - TB_W'(d), '0);
  endtask

  // One item of random noise over the whole field ranges.
  task automatic send_noise();
    send(3'($urandom_range(7, 0)), $urandom, 3'($urandom_range(7, 0)),
         5'($urandom_range(31, 0)));
  endtask

  task automatic run_phase(input logic [TB_W-1:0] base, input int unsigned n_items);
    int unsigned r;
    write_base(base);
    send(FN_STOP, '0, '0, '0);
    repeat (5) connect_small();
    repeat (2) send(FN_CONNECT, $urandom, 3'($urandom_range(7, 0)), '0);
    repeat (6) send(FN_ENABLE, '0, '0, 5'($urandom_range(N_CHAN, 1)));
    send(FN_START, '0, '0, '0);
    for (int unsigned i = 0; i < n_items; i++) begin
      r = $urandom_range(99, 0);
      // mostly ticks; toggle enables now and then; a little noise
      if (r < 70)      send(FN_TICK, $urandom, '0, '0);
      else if (r < 80) send(FN_ENABLE, '0, '0, 5'($urandom_range(N_CHAN, 1)));
      else if (r < 88) send(FN_DISABLE, '0, '0, 5'($urandom_range(N_CHAN, 1)));
      else             send_noise();
    end
    send(FN_STOP, '0, '0, '0);
    send(FN_TICK, '0, '0, '0);
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FN_STOP;
    in_count      = '0;
    in_timebase   = '0;
    in_channel_id = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    gap_pct       = 0;
    cur_base      = TB_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refusals, the conversion paths and the first-entry disable
    send(FN_TICK, '0, '0, '0);                       // tick while stopped
    send(3'd6, '0, '0, '0);                          // unknown codes
    send(3'd7, '1, '1, '1);
    send(FN_ENABLE, '0, '0, 5'd0);                   // id zero, then unconnected id
    send(FN_DISABLE, '0, '0, 5'd31);
    send(FN_CONNECT, 32'd0, 3'd3, '0);               // zero count
    send(FN_CONNECT, 32'd5, 3'd7, '0);               // timebase out of range
    send(FN_CONNECT, 32'd1001, 3'd0, '0);            // finer, not divisible
    send(FN_CONNECT, 32'hFFFF_FFFF, 3'd6, '0);       // compare overflow
    send(FN_CONNECT, 32'd2000, 3'd0, '0);            // finer, divisible: 2
    send(FN_CONNECT, 32'd1, 3'd3, '0);               // same timebase: 1
    send(FN_CONNECT, 32'd3, 3'd3, '0);
    send(FN_ENABLE, '0, '0, 5'd1);
    send(FN_ENABLE, '0, '0, 5'd2);
    send(FN_ENABLE, '0, '0, 5'd3);
    send(FN_DISABLE, '0, '0, 5'd1);                  // first entry disable
    send(FN_START, '0, '0, '0);
    send(FN_START, '0, '0, '0);
    send(FN_CONNECT, 32'd4, 3'd3, '0);               // connect while running
    send(FN_ENABLE, '0, '0, 5'd1);
    repeat (4) send(FN_TICK, '0, '0, '0);
    send(FN_STOP, '0, '0, '0);
    send(FN_STOP, '0, '0, '0);

    // out-of-range register value must be dropped, then sweep the extremes
    write_base(3'd7);
    gap_pct = 26;
    run_phase(3'd6, 75);
    gap_pct = 56;
    run_phase(3'd0, 75);
    gap_pct = 0;
    run_phase(3'd3, 75);
    // table is full by now: a further connect must be refused
    repeat (3) connect_small();

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== multi_channel_periodic_event_timer_top.f =====
design/mcpet_pkg.sv
design/multi_channel_periodic_event_timer_top.sv
sim/mcpet_checker.sv
sim/tb.sv
